// ===== design/q2rpy_pkg.sv =====
// package: shared constants, types and arctangent table for quaternion to euler
package q2rpy_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned MW = 66;
  localparam logic signed [31:0] PI_FX = 32'sd1686629713;
  localparam logic signed [31:0] HALF_PI_FX = 32'sd843314857;

  typedef logic signed [MW-1:0] mterm_t;
  typedef logic signed [33:0] ang_t;

  typedef struct packed {
    logic signed [MW-1:0] x;
    logic signed [MW-1:0] y;
    ang_t z;
    logic zero;
  } cvec_t;

  function automatic ang_t step_angle(input int unsigned i);
    ang_t a;
    a = '0;
    case (i)
      0: a = 34'sd421657428;
      1: a = 34'sd248918915;
      2: a = 34'sd131521918;
      3: a = 34'sd66762579;
      4: a = 34'sd33510843;
      5: a = 34'sd16771758;
      6: a = 34'sd8387925;
      7: a = 34'sd4194219;
      8: a = 34'sd2097141;
      9: a = 34'sd1048575;
      default: begin
        if (i < 30) a = ang_t'(34'sd1 <<< (29 - i));
        else a = '0;
      end
    endcase
    return a;
  endfunction

endpackage

// ===== design/q2rpy_if.sv =====
// interfaces: valid/ready channels for quaternion input and angle output
interface q2rpy_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface q2rpy_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] roll;
  logic signed [30:0] pitch;
  logic signed [31:0] yaw;
  logic domain_flag;
  modport source (output valid, roll, pitch, yaw, domain_flag, input ready);
  modport sink (input valid, roll, pitch, yaw, domain_flag, output ready);
endinterface

// ===== design/q2rpy_cordic.sv =====
// module: pipelined vectoring cordic atan2, one register stage per iteration
module q2rpy_cordic import q2rpy_pkg::*; #(
  parameter int STEPS = 28
) (
  input  logic clk,
  input  logic en,
  input  mterm_t y_in,
  input  mterm_t x_in,
  output ang_t z_out
);

  cvec_t st_r [STEPS+1];
  cvec_t st0_nxt;
  mterm_t xs, ys;

  always_comb begin
    xs = x_in >>> 4;
    ys = y_in >>> 4;
    st0_nxt.zero = (x_in == '0) && (y_in == '0);
    st0_nxt.x = xs;
    st0_nxt.y = ys;
    st0_nxt.z = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        st0_nxt.x = ys;
        st0_nxt.y = -xs;
        st0_nxt.z = ang_t'(HALF_PI_FX);
      end else begin
        st0_nxt.x = -ys;
        st0_nxt.y = xs;
        st0_nxt.z = -ang_t'(HALF_PI_FX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) st_r[0] <= st0_nxt;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    cvec_t it_nxt;
    always_comb begin
      it_nxt = st_r[i];
      if (st_r[i].y >= 0) begin
        it_nxt.x = st_r[i].x + (st_r[i].y >>> i);
        it_nxt.y = st_r[i].y - (st_r[i].x >>> i);
        it_nxt.z = st_r[i].z + step_angle(i);
      end else begin
        it_nxt.x = st_r[i].x - (st_r[i].y >>> i);
        it_nxt.y = st_r[i].y + (st_r[i].x >>> i);
        it_nxt.z = st_r[i].z - step_angle(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en) st_r[i+1] <= it_nxt;
    end
  end

  always_comb begin
    if (st_r[STEPS].zero) z_out = '0;
    else if (st_r[STEPS].z > ang_t'(PI_FX)) z_out = ang_t'(PI_FX);
    else if (st_r[STEPS].z < -ang_t'(PI_FX)) z_out = -ang_t'(PI_FX);
    else z_out = st_r[STEPS].z;
  end

endmodule

// ===== design/quaternion_to_roll_pitch_yaw.sv =====
// top level: quaternion to roll, pitch and yaw with pipelined cordic units
//   channel | dir | fields
//   in_     | in  | quat_x quat_y quat_z quat_w (32b signed, 2^29)
//   out_    | out | roll yaw (32b) pitch (31b) domain_flag
// one item per cycle while the output is not stalled; registered stages in order
// (products, m terms, radicand, 31-step square root, cordic pre-rotation,
//  cordic stages, output register)
// the whole pipeline advances only when the output register can take data
// rst_n clears valid bits only; payload registers are not reset
module quaternion_to_roll_pitch_yaw import q2rpy_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int CORDIC_STEPS = 28
) (
  input  logic clk,
  input  logic rst_n,
  q2rpy_in_if.sink in_ch,
  q2rpy_out_if.source out_ch
);

  localparam int IB = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int SQ = 31;
  localparam int LAT = 4 + SQ + CORDIC_STEPS;

  logic en;
  logic [LAT-1:0] vld_r;
  logic out_vld_r;

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
      out_vld_r <= vld_r[LAT-1];
    end
  end
  assign out_ch.valid = out_vld_r;

  // stage 1: products
  logic signed [31:0] x, y, z, w;
  assign x = 32'(signed'(in_ch.quat_x[IB-1:0]));
  assign y = 32'(signed'(in_ch.quat_y[IB-1:0]));
  assign z = 32'(signed'(in_ch.quat_z[IB-1:0]));
  assign w = 32'(signed'(in_ch.quat_w[IB-1:0]));
  logic signed [63:0] xx_r, yy_r, zz_r, ww_r, yz_r, xw_r, xz_r, yw_r, xy_r, zw_r;
  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= x * x; yy_r <= y * y; zz_r <= z * z; ww_r <= w * w;
      yz_r <= y * z; xw_r <= x * w; xz_r <= x * z; yw_r <= y * w;
      xy_r <= x * y; zw_r <= z * w;
    end
  end

  // stage 2: matrix terms
  mterm_t xx, yy, zz, ww;
  mterm_t m21_r, m22_r, m20_r, m10_r, m00_r;
  assign xx = mterm_t'(xx_r >>> 2);
  assign yy = mterm_t'(yy_r >>> 2);
  assign zz = mterm_t'(zz_r >>> 2);
  assign ww = mterm_t'(ww_r >>> 2);
  always_ff @(posedge clk) begin
    if (en) begin
      m21_r <= mterm_t'(yz_r >>> 1) - mterm_t'(xw_r >>> 1);
      m22_r <= zz + ww - xx - yy;
      m20_r <= mterm_t'(xz_r >>> 1) + mterm_t'(yw_r >>> 1);
      m10_r <= mterm_t'(xy_r >>> 1) - mterm_t'(zw_r >>> 1);
      m00_r <= xx - yy - zz + ww;
    end
  end

  // saturate m20 and build radicand
  logic signed [31:0] s_nxt;
  logic dom_nxt;
  logic signed [63:0] ssq;
  always_comb begin
    s_nxt = 32'(m20_r >>> 26);
    dom_nxt = 1'b0;
    if (m20_r > (mterm_t'(1) <<< 56)) begin
      s_nxt = 32'sd1073741824; dom_nxt = 1'b1;
    end else if (m20_r < -(mterm_t'(1) <<< 56)) begin
      s_nxt = -32'sd1073741824; dom_nxt = 1'b1;
    end
    ssq = s_nxt * s_nxt;
  end

  // square root pipeline, one result bit per stage, delays other terms along
  typedef struct packed {
    logic [61:0] v;
    logic [61:0] r;
    logic signed [31:0] s;
    logic dom;
    mterm_t m21, m22, m10, m00;
  } sq_t;
  sq_t sq_r [SQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].v <= 62'((64'sd1 <<< 60) - ssq);
      sq_r[0].r <= '0;
      sq_r[0].s <= s_nxt;
      sq_r[0].dom <= dom_nxt;
      sq_r[0].m21 <= m21_r; sq_r[0].m22 <= m22_r;
      sq_r[0].m10 <= m10_r; sq_r[0].m00 <= m00_r;
    end
  end

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (2 * (SQ - 1 - k));
    sq_t n;
    always_comb begin
      n = sq_r[k];
      if (sq_r[k].v >= sq_r[k].r + BIT) begin
        n.v = sq_r[k].v - (sq_r[k].r + BIT);
        n.r = (sq_r[k].r >> 1) + BIT;
      end else begin
        n.r = sq_r[k].r >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) sq_r[k+1] <= n;
    end
  end

  sq_t sqe;
  assign sqe = sq_r[SQ];

  // dom bit delay through cordic
  logic dom_r [CORDIC_STEPS+1];
  always_ff @(posedge clk) begin
    if (en) dom_r[0] <= sqe.dom;
  end
  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_dom
    always_ff @(posedge clk) begin
      if (en) dom_r[j+1] <= dom_r[j];
    end
  end

  ang_t roll_a, yaw_a, pitch_a;
  q2rpy_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en), .y_in(sqe.m21), .x_in(sqe.m22), .z_out(roll_a));
  q2rpy_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en), .y_in(sqe.m10), .x_in(sqe.m00), .z_out(yaw_a));
  q2rpy_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en),
    .y_in(mterm_t'(sqe.s) <<< 26),
    .x_in(mterm_t'({1'b0, sqe.r[30:0]}) <<< 26),
    .z_out(pitch_a));

  logic signed [31:0] roll_r, yaw_r;
  logic signed [30:0] pitch_r;
  logic dom_out_r;
  ang_t pc;
  always_comb begin
    pc = pitch_a;
    if (pc > ang_t'(HALF_PI_FX)) pc = ang_t'(HALF_PI_FX);
    else if (pc < -ang_t'(HALF_PI_FX)) pc = -ang_t'(HALF_PI_FX);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      roll_r <= 32'(-roll_a);
      yaw_r <= 32'(-yaw_a);
      pitch_r <= 31'(pc);
      dom_out_r <= dom_r[CORDIC_STEPS];
    end
  end
  assign out_ch.roll = roll_r;
  assign out_ch.yaw = yaw_r;
  assign out_ch.pitch = pitch_r;
  assign out_ch.domain_flag = dom_out_r;

endmodule

// ===== design/q2rpy_checker.sv =====
// checker: port-level properties of the quaternion to euler block, with bind
module q2rpy_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [31:0] roll,
  input logic signed [30:0] pitch,
  input logic signed [31:0] yaw
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(roll) && $stable(pitch) && $stable(yaw))
    else $error("result dropped during stall");
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_roll_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> roll <= 32'sd1686629713 && roll >= -32'sd1686629713)
    else $error("roll out of range");
  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pitch <= 31'sd843314857 && pitch >= -31'sd843314857)
    else $error("pitch out of range");

endmodule

bind quaternion_to_roll_pitch_yaw q2rpy_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .roll(out_ch.roll), .pitch(out_ch.pitch), .yaw(out_ch.yaw));

// ===== sim/quaternion_to_roll_pitch_yaw_tb.sv =====
// testbench: random and directed quaternions checked against a fixed-point euler angle predictor
`timescale 1ns / 1ps

module quaternion_to_roll_pitch_yaw_tb;
  import q2rpy_pkg::*;

  localparam int NUM_RANDOM = 1730;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;
  localparam int STEPS = 28;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } quat_t;

  typedef struct {
    logic signed [31:0] roll;
    logic signed [30:0] pitch;
    logic signed [31:0] yaw;
    logic dom;
  } angles_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  q2rpy_in_if in_if();
  q2rpy_out_if out_if();

  quaternion_to_roll_pitch_yaw uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  always #2 clk = ~clk;

  quat_t pending_q[$];
  angles_t angles_q[$];
  int n_total = 0;
  int n_popped = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_dom = 0;
  int gap_left = 0;
  int burst_left = 4;
  int stall_left = 0;
  int run_left = 10;
  int cycles = 0;
  bit in_took = 1'b0;

  function automatic longint arctan_step(int i);
    longint tab[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                        16771758, 8387925, 4194219, 2097141, 1048575};
    if (i < 10) return tab[i];
    if (i < 30) return longint'(1) <<< (29 - i);
    return 0;
  endfunction

  function automatic longint vec_atan2(longint y, longint x);
    longint z, t, dx, dy, lim;
    z = 0;
    lim = 1686629713;
    if (x == 0 && y == 0) return 0;
    x = x >>> 4;
    y = y >>> 4;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 843314857;
      end else begin
        t = x; x = -y; y = t; z = -843314857;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_step(i);
      end else begin
        x -= dx; y += dy; z -= arctan_step(i);
      end
    end
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic angles_t euler_angles(quat_t q);
    angles_t a;
    longint x, y, z, w, xx, yy, zz, ww, m21, m22, m20, m10, m00, s, c, p, one56;
    x = q.x; y = q.y; z = q.z; w = q.w;
    one56 = longint'(1) <<< 56;
    xx = (x * x) >>> 2;
    yy = (y * y) >>> 2;
    zz = (z * z) >>> 2;
    ww = (w * w) >>> 2;
    m21 = ((y * z) >>> 1) - ((x * w) >>> 1);
    m22 = zz + ww - xx - yy;
    m20 = ((x * z) >>> 1) + ((y * w) >>> 1);
    m10 = ((x * y) >>> 1) - ((z * w) >>> 1);
    m00 = xx - yy - zz + ww;
    a.roll = 32'(-vec_atan2(m21, m22));
    a.yaw = 32'(-vec_atan2(m10, m00));
    s = m20 >>> 26;
    a.dom = 1'b0;
    if (m20 > one56) begin
      s = longint'(1) <<< 30; a.dom = 1'b1;
    end else if (m20 < -one56) begin
      s = -(longint'(1) <<< 30); a.dom = 1'b1;
    end
    c = int_sqrt(longint'(unsigned'((longint'(1) <<< 60) - s * s)));
    p = vec_atan2(s <<< 26, c <<< 26);
    if (p > 843314857) p = 843314857;
    if (p < -843314857) p = -843314857;
    a.pitch = 31'(p);
    return a;
  endfunction

  function automatic logic signed [31:0] rand_comp(int mode);
    logic signed [31:0] v;
    v = $urandom;
    case (mode)
      0: return v >>> (3 + $urandom_range(0, 2));
      1: return v >>> $urandom_range(3, 28);
      default: return v;
    endcase
  endfunction

  task automatic add_quat(logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] z, logic signed [31:0] w);
    quat_t q;
    q.x = x; q.y = y; q.z = z; q.w = w;
    pending_q.push_back(q);
    n_total++;
  endtask

  // sampler: transfer on input predicts, transfer on output checks
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_took <= in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      quat_t q;
      q.x = in_if.quat_x; q.y = in_if.quat_y; q.z = in_if.quat_z; q.w = in_if.quat_w;
      angles_q.push_back(euler_angles(q));
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (angles_q.size() == 0) begin
        $display("%0t unexpected result roll=%0d pitch=%0d yaw=%0d dom=%0b", $time,
                 out_if.roll, out_if.pitch, out_if.yaw, out_if.domain_flag);
        n_errors++;
      end else begin
        angles_t e;
        e = angles_q.pop_front();
        n_checked++;
        if (e.dom) n_dom++;
        if (out_if.roll !== e.roll) begin
          $display("%0t roll expected %0d actual %0d", $time, e.roll, out_if.roll);
          n_errors++;
        end
        if (out_if.pitch !== e.pitch) begin
          $display("%0t pitch expected %0d actual %0d", $time, e.pitch, out_if.pitch);
          n_errors++;
        end
        if (out_if.yaw !== e.yaw) begin
          $display("%0t yaw expected %0d actual %0d", $time, e.yaw, out_if.yaw);
          n_errors++;
        end
        if (out_if.domain_flag !== e.dom) begin
          $display("%0t domain_flag expected %0b actual %0b", $time, e.dom,
                   out_if.domain_flag);
          n_errors++;
        end
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.quat_x = '0; in_if.quat_y = '0; in_if.quat_z = '0; in_if.quat_w = '0;
    out_if.ready = 1'b0;
  end

  // driver: bursts and gaps, two pauses until all results are back
  always @(negedge clk) begin
    if (rst_n && !(in_if.valid && !in_took)) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() == 0 ||
                   ((n_popped == 40 || n_popped == 900) && angles_q.size() != 0)) begin
        in_if.valid <= 1'b0;
      end else begin
        quat_t q;
        q = pending_q.pop_front();
        n_popped <= n_popped + 1;
        in_if.valid <= 1'b1;
        in_if.quat_x <= q.x; in_if.quat_y <= q.y;
        in_if.quat_z <= q.z; in_if.quat_w <= q.w;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (run_left > 0) begin
        out_if.ready <= 1'b1;
        run_left <= run_left - 1;
      end else begin
        out_if.ready <= 1'b1;
        run_left <= $urandom_range(1, 60);
        stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("quaternion_to_roll_pitch_yaw_tb: errors");
      $finish;
    end
  end

  initial begin
    int mode;
    add_quat(0, 0, 0, 0);
    add_quat(0, 0, 0, 32'sh2000_0000);
    add_quat(32'sh2000_0000, 0, 0, 0);
    add_quat(0, 32'sh2000_0000, 0, 0);
    add_quat(0, 0, 32'sh2000_0000, 0);
    add_quat(0, 0, 0, -32'sh2000_0000);
    add_quat(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    add_quat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_quat(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    add_quat(32'sh7fff_ffff, 0, 32'sh8000_0000, 0);
    add_quat(32'sh16a0_9e66, 0, 32'sh16a0_9e66, 0);
    add_quat(-32'sh16a0_9e66, 0, 32'sh16a0_9e66, 0);
    add_quat(0, 32'sh16a0_9e66, 0, 32'sh16a0_9e66);
    add_quat(0, 32'sh1700_0000, 0, 32'sh1700_0000);
    add_quat(0, -32'sh1700_0000, 0, 32'sh1700_0000);
    add_quat(32'sh1000_0000, 32'sh1000_0000, 32'sh1000_0000, 32'sh1000_0000);
    add_quat(-32'sh1000_0000, 32'sh1000_0000, -32'sh1000_0000, -32'sh1000_0000);
    add_quat(32'sh16a0_9e66, 0, 0, 32'sh16a0_9e66);
    add_quat(0, 0, -32'sh16a0_9e66, -32'sh16a0_9e66);
    add_quat(1, -1, 1, -1);
    add_quat(32'shffff_ffff, 0, 0, 32'sh0000_0001);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        add_quat(rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0));
      end else if (mode == 6) begin
        add_quat(rand_comp(1), rand_comp(1), rand_comp(1), rand_comp(1));
      end else if (mode == 7) begin
        add_quat(rand_comp(2), rand_comp(2), rand_comp(2), rand_comp(2));
      end else begin
        logic signed [31:0] a, b;
        a = 32'sh16a0_9e66 + $signed(32'($urandom_range(0, 1 << 22))) - (1 <<< 21);
        b = 32'sh16a0_9e66 + $signed(32'($urandom_range(0, 1 << 22))) - (1 <<< 21);
        if ($urandom_range(0, 1)) add_quat(a, rand_comp(1), a, rand_comp(1));
        else add_quat(rand_comp(1), b, -rand_comp(1), -b);
      end
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && !in_if.valid && angles_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d quaternions, checked %0d angle sets, %0d with saturated pitch",
             n_total, n_checked, n_dom);
    if (n_errors == 0 && angles_q.size() == 0) begin
      $display("quaternion_to_roll_pitch_yaw_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, angles_q.size());
      $display("quaternion_to_roll_pitch_yaw_tb: errors");
    end
    $finish;
  end

endmodule
